>>> rtl/hqm_pkg.sv
`timescale 1ns / 1ps

package hqm_pkg;

    localparam int COMPONENT_BITS_DEF     = 16;
    localparam int MASK_FRACTION_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int HUE_FULL  = 23040;
    localparam int HUE_HALF  = 11520;
    localparam int HUE_SIXTH = 3840;
    localparam int HUE_W     = 15;

    localparam int SAT_FRAC = 12;
    localparam int SAT_QW   = 13;
    localparam int THR_W    = 16;
    localparam int RAMP_W   = 16;

    localparam logic [15:0] LUMA_COEF_R   = 16'd13933;
    localparam logic [15:0] LUMA_COEF_G   = 16'd46871;
    localparam logic [15:0] LUMA_COEF_B   = 16'd4732;
    localparam int          LUMA_ROUND    = 32768;
    localparam int          LUMA_SHIFT    = 16;
    localparam logic [15:0] LUMA_TOP_OPEN = 16'hFFFF;

    localparam int RAMP_COUNT   = 5;
    localparam int RAMP_HUE     = 0;
    localparam int RAMP_SAT_LO  = 1;
    localparam int RAMP_SAT_HI  = 2;
    localparam int RAMP_LUMA_LO = 3;
    localparam int RAMP_LUMA_HI = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE,
        CFG_HUE_CENTRE,
        CFG_HUE_INNER,
        CFG_HUE_OUTER,
        CFG_SAT_LOW,
        CFG_SAT_HIGH,
        CFG_LUMA_LOW,
        CFG_LUMA_HIGH
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic              fixed;
        logic              full;
        logic [RAMP_W-1:0] gap;
        logic [RAMP_W-1:0] span;
    } t_ramp;

endpackage

>>> rtl/hsl_qualifier_mask.sv
`timescale 1ns / 1ps

// Soft HSL qualifier: one linear RGB pixel in, one selection mask out.
// A pixel transfer happens at a rising edge where start is high and busy is
// low; busy is held low, so a pixel may be offered in every cycle.
// The mask appears on o_mask for exactly one cycle, marked by o_mask_valid,
// and pixels leave in the order they arrived. Throughput is one pixel per
// cycle. The pipeline holds two long-division pipelines in series, one
// quotient bit per stage: 13 stages for hue and saturation, then
// MASK_FRACTION_BITS stages for the ramp positions, plus smoothstep and
// product stages.
// Registers are written over the cfg channel (i_cfg_valid, o_cfg_ready,
// index, data); o_cfg_ready is always high. Write them only while no pixel
// is in flight. The receiver cannot stall the output; every strobe must be
// taken. A synchronous reset zeroes the configuration registers and
// empties the pipeline; the block is then disabled and returns full mask.
module hsl_qualifier_mask #(
    parameter int COMPONENT_BITS     = hqm_pkg::COMPONENT_BITS_DEF,
    parameter int MASK_FRACTION_BITS = hqm_pkg::MASK_FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [COMPONENT_BITS-1:0]           i_red,
    input  logic [COMPONENT_BITS-1:0]           i_green,
    input  logic [COMPONENT_BITS-1:0]           i_blue,
    output logic                                o_mask_valid,
    output logic [MASK_FRACTION_BITS:0]         o_mask,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hqm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hqm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import hqm_pkg::*;

    localparam int C  = COMPONENT_BITS;
    localparam int F  = MASK_FRACTION_BITS;
    localparam int NW = C + SAT_QW;
    localparam int VW = ((C > 17) ? C : 17) + 2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    function automatic t_ramp ramp_rise(input logic signed [VW-1:0] v,
                                        input logic signed [VW-1:0] outer,
                                        input logic signed [VW-1:0] inner);
        t_ramp r;
        logic signed [VW-1:0] dv;
        logic signed [VW-1:0] sp;
        dv      = v - outer;
        sp      = inner - outer;
        r.fixed = 1'b1;
        r.full  = 1'b0;
        r.gap   = dv[RAMP_W-1:0];
        r.span  = sp[RAMP_W-1:0];
        if (inner <= outer) begin
            r.full = (v >= inner);
        end else if (v <= outer) begin
            r.full = 1'b0;
        end else if (v >= inner) begin
            r.full = 1'b1;
        end else begin
            r.fixed = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [F:0] mul_round(input logic [F:0] a, input logic [F:0] b);
        logic [2*F+1:0] p;
        p = (2*F+2)'(a) * (2*F+2)'(b) + (2*F+2)'(ONE >> 1);
        return p[2*F:F];
    endfunction

    function automatic logic signed [VW-1:0] sx16(input logic [THR_W-1:0] x);
        return VW'($signed(x));
    endfunction

    function automatic logic signed [VW-1:0] zx16(input logic [THR_W-1:0] x);
        return $signed(VW'(x));
    endfunction

    // Configuration registers.
    logic              r_enable;
    logic [HUE_W-1:0]  r_hue_centre;
    logic [THR_W-1:0]  r_hue_inner;
    logic [THR_W-1:0]  r_hue_outer;
    logic [31:0]       r_sat_low;
    logic [31:0]       r_sat_high;
    logic [31:0]       r_luma_low;
    logic [31:0]       r_luma_high;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_hue_centre <= '0;
            r_hue_inner  <= '0;
            r_hue_outer  <= '0;
            r_sat_low    <= '0;
            r_sat_high   <= '0;
            r_luma_low   <= '0;
            r_luma_high  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_HUE_CENTRE: r_hue_centre <= i_cfg_data[HUE_W-1:0];
                CFG_HUE_INNER:  r_hue_inner  <= i_cfg_data[THR_W-1:0];
                CFG_HUE_OUTER:  r_hue_outer  <= i_cfg_data[THR_W-1:0];
                CFG_SAT_LOW:    r_sat_low    <= i_cfg_data;
                CFG_SAT_HIGH:   r_sat_high   <= i_cfg_data;
                CFG_LUMA_LOW:   r_luma_low   <= i_cfg_data;
                CFG_LUMA_HIGH:  r_luma_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: maximum, minimum, hue sector and luma products.
    logic [C-1:0]        w1_high;
    logic [C-1:0]        w1_low;
    t_sector             w1_sector;
    logic signed [C:0]   w1_diff;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            w1_high   = i_red;
            w1_sector = SEC_RED;
            w1_diff   = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            w1_high   = i_green;
            w1_sector = SEC_GREEN;
            w1_diff   = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            w1_high   = i_blue;
            w1_sector = SEC_BLUE;
            w1_diff   = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        w1_low = i_red;
        if (i_green < w1_low) begin
            w1_low = i_green;
        end
        if (i_blue < w1_low) begin
            w1_low = i_blue;
        end
    end

    logic               r1_valid;
    logic [C-1:0]       r1_high;
    logic [C-1:0]       r1_range;
    t_sector            r1_sector;
    logic signed [C:0]  r1_diff;
    logic [C+15:0]      r1_pr;
    logic [C+15:0]      r1_pg;
    logic [C+15:0]      r1_pb;

    always_ff @(posedge i_clk) begin
        r1_high   <= w1_high;
        r1_range  <= w1_high - w1_low;
        r1_sector <= w1_sector;
        r1_diff   <= w1_diff;
        r1_pr     <= {16'b0, i_red}   * {{C{1'b0}}, LUMA_COEF_R};
        r1_pg     <= {16'b0, i_green} * {{C{1'b0}}, LUMA_COEF_G};
        r1_pb     <= {16'b0, i_blue}  * {{C{1'b0}}, LUMA_COEF_B};
    end

    // Stage 2: dividends and luma.
    logic [C:0]      w2_neg_diff;
    logic [C-1:0]    w2_abs;
    logic [C+17:0]   w2_luma_sum;

    assign w2_neg_diff = -r1_diff;
    assign w2_abs      = r1_diff[C] ? w2_neg_diff[C-1:0] : r1_diff[C-1:0];
    assign w2_luma_sum = (C+18)'(r1_pr) + (C+18)'(r1_pg) + (C+18)'(r1_pb)
                       + (C+18)'(LUMA_ROUND);

    logic            r2_valid;
    logic [NW-1:0]   r2_sat_num;
    logic [NW-1:0]   r2_hue_num;
    logic [C-1:0]    r2_high;
    logic [C-1:0]    r2_range;
    logic [C-1:0]    r2_luma;
    t_sector         r2_sector;
    logic            r2_neg;
    logic            r2_high_zero;
    logic            r2_range_zero;

    always_ff @(posedge i_clk) begin
        r2_sat_num    <= {1'b0, r1_range, {SAT_FRAC{1'b0}}} + NW'(r1_high >> 1);
        r2_hue_num    <= {{SAT_QW{1'b0}}, w2_abs} * NW'(HUE_SIXTH) + NW'(r1_range >> 1);
        r2_high       <= r1_high;
        r2_range      <= r1_range;
        r2_luma       <= w2_luma_sum[C+LUMA_SHIFT-1:LUMA_SHIFT];
        r2_sector     <= r1_sector;
        r2_neg        <= r1_diff[C];
        r2_high_zero  <= (r1_high == '0);
        r2_range_zero <= (r1_range == '0);
    end

    // Saturation and hue dividers.
    logic               w_sv;
    logic [SAT_QW-1:0]  w_sq;
    logic [C:0]         w_sside;
    logic               w_hv;
    logic [SAT_QW-1:0]  w_hq;
    logic [3:0]         w_hside;

    hqm_div #(.DW(C), .QW(SAT_QW), .SW(C + 1)) u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (r2_sat_num),
        .i_den   (r2_high),
        .i_side  ({r2_luma, r2_high_zero}),
        .o_valid (w_sv),
        .o_quot  (w_sq),
        .o_side  (w_sside)
    );

    hqm_div #(.DW(C), .QW(SAT_QW), .SW(4)) u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (r2_hue_num),
        .i_den   (r2_range),
        .i_side  ({r2_sector, r2_neg, r2_range_zero}),
        .o_valid (w_hv),
        .o_quot  (w_hq),
        .o_side  (w_hside)
    );

    // Stage 3: hue and saturation.
    logic signed [16:0] w3_base;
    logic signed [16:0] w3_q;
    logic signed [16:0] w3_hue;

    always_comb begin
        case (t_sector'(w_hside[3:2]))
            SEC_RED:   w3_base = '0;
            SEC_GREEN: w3_base = $signed(17'(2 * HUE_SIXTH));
            SEC_BLUE:  w3_base = $signed(17'(4 * HUE_SIXTH));
            default:   w3_base = '0;
        endcase
        w3_q   = $signed({4'b0, w_hq});
        w3_hue = w_hside[1] ? (w3_base - w3_q) : (w3_base + w3_q);
        if (w3_hue < 0) begin
            w3_hue = w3_hue + $signed(17'(HUE_FULL));
        end
        if (w_hside[0]) begin
            w3_hue = '0;
        end
    end

    logic               r3_valid;
    logic [HUE_W-1:0]   r3_hue;
    logic [SAT_QW-1:0]  r3_sat;
    logic [C-1:0]       r3_luma;

    always_ff @(posedge i_clk) begin
        r3_hue  <= w3_hue[HUE_W-1:0];
        r3_sat  <= w_sside[0] ? '0 : w_sq;
        r3_luma <= w_sside[C:1];
    end

    // Stage 4: wrapped distance to the hue centre.
    logic [HUE_W-1:0]   w4_centre;
    logic signed [15:0] w4_diff;
    logic signed [15:0] w4_neg;
    logic [HUE_W-1:0]   w4_abs;

    assign w4_centre = (r_hue_centre >= HUE_W'(HUE_FULL))
                     ? (r_hue_centre - HUE_W'(HUE_FULL)) : r_hue_centre;
    assign w4_diff   = $signed({1'b0, r3_hue}) - $signed({1'b0, w4_centre});
    assign w4_neg    = -w4_diff;
    assign w4_abs    = w4_diff[15] ? w4_neg[HUE_W-1:0] : w4_diff[HUE_W-1:0];

    logic               r4_valid;
    logic [HUE_W-1:0]   r4_dist;
    logic [SAT_QW-1:0]  r4_sat;
    logic [C-1:0]       r4_luma;

    always_ff @(posedge i_clk) begin
        r4_dist <= (w4_abs > HUE_W'(HUE_HALF)) ? (HUE_W'(HUE_FULL) - w4_abs) : w4_abs;
        r4_sat  <= r3_sat;
        r4_luma <= r3_luma;
    end

    // Stage 5: ramp classification. A falling ramp is a rising ramp on
    // negated values.
    logic signed [VW-1:0] w5_hue;
    logic signed [VW-1:0] w5_sat;
    logic signed [VW-1:0] w5_luma;
    t_ramp                w5_ramp [RAMP_COUNT];

    assign w5_hue  = $signed(VW'(r4_dist));
    assign w5_sat  = $signed(VW'(r4_sat));
    assign w5_luma = $signed(VW'(r4_luma));

    always_comb begin
        w5_ramp[RAMP_HUE] = ramp_rise(-w5_hue, -zx16(r_hue_outer), -zx16(r_hue_inner));
        if (r_hue_inner >= THR_W'(HUE_HALF)) begin
            w5_ramp[RAMP_HUE].fixed = 1'b1;
            w5_ramp[RAMP_HUE].full  = 1'b1;
        end
        w5_ramp[RAMP_SAT_LO] = ramp_rise(w5_sat, sx16(r_sat_low[15:0]),
                                         sx16(r_sat_low[31:16]));
        w5_ramp[RAMP_SAT_HI] = ramp_rise(-w5_sat, -sx16(r_sat_high[15:0]),
                                         -sx16(r_sat_high[31:16]));
        w5_ramp[RAMP_LUMA_LO] = ramp_rise(w5_luma, zx16(r_luma_low[15:0]),
                                          zx16(r_luma_low[31:16]));
        w5_ramp[RAMP_LUMA_HI] = ramp_rise(-w5_luma, -zx16(r_luma_high[15:0]),
                                          -zx16(r_luma_high[31:16]));
        if (r_luma_high[15:0] == LUMA_TOP_OPEN) begin
            w5_ramp[RAMP_LUMA_HI].fixed = 1'b1;
            w5_ramp[RAMP_LUMA_HI].full  = 1'b1;
        end
    end

    logic   r5_valid;
    t_ramp  r5_ramp [RAMP_COUNT];

    always_ff @(posedge i_clk) begin
        r5_ramp <= w5_ramp;
    end

    // Ramp position dividers.
    logic [RAMP_COUNT-1:0] w_rv;
    logic [F-1:0]          w_rq    [RAMP_COUNT];
    logic [1:0]            w_rside [RAMP_COUNT];

    for (genvar k = 0; k < RAMP_COUNT; k++) begin : g_ramp
        hqm_div #(.DW(RAMP_W), .QW(F), .SW(2)) u_ramp_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r5_valid),
            .i_num   ({r5_ramp[k].gap, {F{1'b0}}}),
            .i_den   (r5_ramp[k].span),
            .i_side  ({r5_ramp[k].fixed, r5_ramp[k].full}),
            .o_valid (w_rv[k]),
            .o_quot  (w_rq[k]),
            .o_side  (w_rside[k])
        );
    end

    // Stages 6 and 7: smoothstep.
    logic           r6_valid;
    logic [2*F-1:0] r6_tt   [RAMP_COUNT];
    logic [F+1:0]   r6_k    [RAMP_COUNT];
    logic [1:0]     r6_side [RAMP_COUNT];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RAMP_COUNT; k++) begin
            r6_tt[k]   <= (2*F)'(w_rq[k]) * (2*F)'(w_rq[k]);
            r6_k[k]    <= (F+2)'(3 * (2 ** F)) - {1'b0, w_rq[k], 1'b0};
            r6_side[k] <= w_rside[k];
        end
    end

    logic [3*F+1:0] w7_p [RAMP_COUNT];

    always_comb begin
        for (int k = 0; k < RAMP_COUNT; k++) begin
            w7_p[k] = (3*F+2)'(r6_tt[k]) * (3*F+2)'(r6_k[k])
                    + ((3*F+2)'(1) << (2*F-1));
        end
    end

    logic       r7_valid;
    logic [F:0] r7_s [RAMP_COUNT];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RAMP_COUNT; k++) begin
            if (r6_side[k][1]) begin
                r7_s[k] <= r6_side[k][0] ? ONE : '0;
            end else begin
                r7_s[k] <= w7_p[k][3*F:2*F];
            end
        end
    end

    // Stages 8 to 10: products.
    logic       r8_valid;
    logic [F:0] r8_hue;
    logic [F:0] r8_sat;
    logic [F:0] r8_luma;
    logic       r9_valid;
    logic [F:0] r9_hs;
    logic [F:0] r9_luma;
    logic       r10_valid;
    logic [F:0] r10_mask;
    logic [F:0] w10_m;

    always_ff @(posedge i_clk) begin
        r8_hue  <= r7_s[RAMP_HUE];
        r8_sat  <= mul_round(r7_s[RAMP_SAT_LO], r7_s[RAMP_SAT_HI]);
        r8_luma <= mul_round(r7_s[RAMP_LUMA_LO], r7_s[RAMP_LUMA_HI]);
        r9_hs   <= mul_round(r8_hue, r8_sat);
        r9_luma <= r8_luma;
    end

    assign w10_m = mul_round(r9_hs, r9_luma);

    always_ff @(posedge i_clk) begin
        if (!r_enable || w10_m > ONE) begin
            r10_mask <= ONE;
        end else begin
            r10_mask <= w10_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
            r4_valid  <= 1'b0;
            r5_valid  <= 1'b0;
            r6_valid  <= 1'b0;
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
        end else begin
            r1_valid  <= start && !busy;
            r2_valid  <= r1_valid;
            r3_valid  <= w_sv && w_hv;
            r4_valid  <= r3_valid;
            r5_valid  <= r4_valid;
            r6_valid  <= &w_rv;
            r7_valid  <= r6_valid;
            r8_valid  <= r7_valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
        end
    end

    assign o_mask_valid = r10_valid;
    assign o_mask       = r10_mask;

endmodule

>>> rtl/hqm_div.sv
`timescale 1ns / 1ps

module hqm_div #(
    parameter int DW = 16,
    parameter int QW = 13,
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [DW+QW-1:0]   i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quot,
    output logic [SW-1:0]      o_side
);

    logic [QW-1:0] r_valid;
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_bits [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    logic [DW-1:0] w_rem  [QW];
    logic [QW-1:0] w_bits [QW];
    logic [DW-1:0] w_den  [QW];
    logic [SW-1:0] w_side [QW];

    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_bits [QW];

    always_comb begin
        w_rem[0]  = i_num[DW+QW-1:QW];
        w_bits[0] = i_num[QW-1:0];
        w_den[0]  = i_den;
        w_side[0] = i_side;
        for (int s = 1; s < QW; s++) begin
            w_rem[s]  = r_rem[s-1];
            w_bits[s] = r_bits[s-1];
            w_den[s]  = r_den[s-1];
            w_side[s] = r_side[s-1];
        end
    end

    always_comb begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        for (int s = 0; s < QW; s++) begin
            trial = {w_rem[s], w_bits[s][QW-1]};
            diff  = trial - {1'b0, w_den[s]};
            if (trial >= {1'b0, w_den[s]}) begin
                n_rem[s]  = diff[DW-1:0];
                n_bits[s] = {w_bits[s][QW-2:0], 1'b1};
            end else begin
                n_rem[s]  = trial[DW-1:0];
                n_bits[s] = {w_bits[s][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_bits <= n_bits;
        r_den  <= w_den;
        r_side <= w_side;
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_bits[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
